// ----- rtl/lsfe_pkg.sv -----
// Shared types and constants for the LED strip frame encoder.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package lsfe_pkg;

	localparam logic [7:0] HDR_BASE     = 8'hE0;
	localparam logic [7:0] BRIGHT_RESET = 8'd22;
	localparam logic [7:0] START_BYTE   = 8'h00;
	localparam logic [7:0] END_BYTE     = 8'hFF;
	localparam logic [7:0] WHEEL_SEG1   = 8'd85;
	localparam logic [7:0] WHEEL_SEG2   = 8'd170;
	localparam logic [7:0] FULL_SCALE   = 8'd255;

	localparam int START_BYTES   = 4;
	localparam int END_BYTES     = 4;
	localparam int BYTES_PER_LED = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		SEL_HDR   = 2'd0,
		SEL_BLUE  = 2'd1,
		SEL_GREEN = 2'd2,
		SEL_RED   = 2'd3
	} byte_sel_t;

	typedef struct packed {
		logic       rainbow;
		logic [3:0] lit_led;
		logic [7:0] hdr_on;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} frame_desc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

endpackage

// ----- rtl/lsfe_front.sv -----
// Front end of the LED strip frame encoder: brightness register, color wheel state,
// and per-item frame descriptor built at accept. Depends on lsfe_pkg.
module lsfe_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [7:0]            brightness,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  mode,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic [3:0]            lit_led,
	input  lsfe_pkg::queue_status_t q_status,
	output logic                  push,
	output lsfe_pkg::frame_desc_t push_desc
);
	import lsfe_pkg::*;

	logic [7:0] bright_q;
	logic [7:0] wheel_pos_q;
	logic [7:0] p;
	logic [7:0] q;
	logic [9:0] q3_wide;
	logic [7:0] u;
	logic [7:0] w_red;
	logic [7:0] w_green;
	logic [7:0] w_blue;

	assign cfg_ready  = 1'b1;
	assign item_stall = q_status.full;
	assign push       = item_valid && !q_status.full;

	always_comb begin
		p = FULL_SCALE - wheel_pos_q;
		if (p < WHEEL_SEG1) begin
			q = p;
		end else if (p < WHEEL_SEG2) begin
			q = p - WHEEL_SEG1;
		end else begin
			q = p - WHEEL_SEG2;
		end
		q3_wide = {2'b00, q} + {1'b0, q, 1'b0};
		u = q3_wide[7:0];
		if (p < WHEEL_SEG1) begin
			w_red   = FULL_SCALE - u;
			w_green = 8'd0;
			w_blue  = u;
		end else if (p < WHEEL_SEG2) begin
			w_red   = 8'd0;
			w_green = u;
			w_blue  = FULL_SCALE - u;
		end else begin
			w_red   = u;
			w_green = FULL_SCALE - u;
			w_blue  = 8'd0;
		end
	end

	always_comb begin
		push_desc.rainbow = mode;
		push_desc.lit_led = lit_led;
		push_desc.hdr_on  = HDR_BASE | {3'b000, bright_q[7:3]};
		push_desc.red     = mode ? w_red   : red;
		push_desc.green   = mode ? w_green : green;
		push_desc.blue    = mode ? w_blue  : blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_q    <= BRIGHT_RESET;
			wheel_pos_q <= 8'd0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				bright_q <= brightness;
			end
			if (push && mode) begin
				wheel_pos_q <= wheel_pos_q + 8'd1;
			end
		end
	end

endmodule

// ----- rtl/lsfe_queue.sv -----
// Two-entry descriptor queue between the front and back of the frame encoder.
// Depends on lsfe_pkg for the descriptor type and depth.
module lsfe_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  lsfe_pkg::frame_desc_t   push_desc,
	input  logic                    pop,
	output lsfe_pkg::frame_desc_t   head,
	output lsfe_pkg::queue_status_t status
);
	import lsfe_pkg::*;

	frame_desc_t       entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = entry_q[rd_ptr_q];
	assign status.empty = (count_q == QCNT_W'(0));
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/lsfe_back.sv -----
// Back end of the frame encoder: walks one refresh byte by byte from the queue head
// into a registered output beat. Depends on lsfe_pkg.
module lsfe_back #(
	parameter int NUM_LEDS = 3
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lsfe_pkg::frame_desc_t   head,
	input  lsfe_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    byte_valid,
	input  logic                    byte_stall,
	output logic [7:0]              spi_byte,
	output logic                    last
);
	import lsfe_pkg::*;

	localparam int FRAME_BYTES = START_BYTES + BYTES_PER_LED * NUM_LEDS + END_BYTES;
	localparam int CNT_W       = $clog2(FRAME_BYTES);
	localparam int LED_W       = CNT_W - 2;

	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] rel;
	logic [LED_W-1:0] led_idx;
	byte_sel_t        sel;
	logic             advance;
	logic             emit;
	logic             is_last;
	logic             led_on;
	logic [7:0]       next_byte;
	logic             valid_q;
	logic [7:0]       byte_q;
	logic             last_q;

	assign advance    = !valid_q || !byte_stall;
	assign emit       = advance && !q_status.empty;
	assign is_last    = (cnt_q == CNT_W'(FRAME_BYTES - 1));
	assign pop        = emit && is_last;
	assign byte_valid = valid_q;
	assign spi_byte   = byte_q;
	assign last       = last_q;

	always_comb begin
		rel     = cnt_q - CNT_W'(START_BYTES);
		led_idx = rel[CNT_W-1:2];
		sel     = byte_sel_t'(rel[1:0]);
		led_on  = head.rainbow || (head.lit_led == 4'(led_idx));
		if (cnt_q < CNT_W'(START_BYTES)) begin
			next_byte = START_BYTE;
		end else if (cnt_q >= CNT_W'(START_BYTES + BYTES_PER_LED * NUM_LEDS)) begin
			next_byte = END_BYTE;
		end else begin
			case (sel)
				SEL_HDR:   next_byte = led_on ? head.hdr_on : HDR_BASE;
				SEL_BLUE:  next_byte = head.blue;
				SEL_GREEN: next_byte = head.green;
				SEL_RED:   next_byte = head.red;
				default:   next_byte = HDR_BASE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (advance) begin
				valid_q <= !q_status.empty;
			end
			if (emit) begin
				cnt_q <= is_last ? '0 : cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= next_byte;
			last_q <= is_last;
		end
	end

`ifndef SYNTHESIS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(FRAME_BYTES - 1) || cnt_q == CNT_W'(FRAME_BYTES - 1))
		else $error("byte counter beyond frame length");
	a_last_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> byte_q == END_BYTE)
		else $error("last beat is not an end-frame byte");
	a_frame_has_desc: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != '0 |-> !q_status.empty)
		else $error("frame in progress without a queued descriptor");
	a_pop_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> cnt_q == '0)
		else $error("counter did not restart after the final byte");
`endif

endmodule

// ----- rtl/led_strip_frame_encoder_unit.sv -----
// Top level of the LED strip frame encoder: front, descriptor queue and byte sequencer.
// Depends on lsfe_pkg, lsfe_front, lsfe_queue and lsfe_back.
//
// Each accepted item produces one refresh of 8 + 4*NUM_LEDS bytes (20 at the default of
// three LEDs): four zero bytes, a header and blue, green, red for each LED, then four 0xFF
// bytes with last set on the final one. The byte sequencer issues one beat per cycle unless
// byte_stall holds the output or the queue is empty; a two-entry descriptor queue lets
// the input side accept up to two items ahead of the byte being sent. Static items color
// every LED but give the brightness only to the LED at lit_led; rainbow items take their
// color from the wheel position and advance it by one. The brightness register is always
// ready and should only be written while the block is idle.
module led_strip_frame_encoder_unit #(
	parameter int NUM_LEDS = 3
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] brightness,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic       mode,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [3:0] lit_led,
	output logic       byte_valid,
	input  logic       byte_stall,
	output logic [7:0] spi_byte,
	output logic       last
);
	import lsfe_pkg::*;

	frame_desc_t   push_desc;
	frame_desc_t   head;
	queue_status_t q_status;
	logic          push;
	logic          pop;

	lsfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.brightness (brightness),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.mode       (mode),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.lit_led    (lit_led),
		.q_status   (q_status),
		.push       (push),
		.push_desc  (push_desc)
	);

	lsfe_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	lsfe_back #(
		.NUM_LEDS (NUM_LEDS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.q_status   (q_status),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.spi_byte   (spi_byte),
		.last       (last)
	);

endmodule
